/* sv/bstg_pkg.sv */
// shared types, constants and helpers for the bezier segment table generator
`timescale 1ns / 1ps

package bstg_pkg;

    localparam int IDX_W     = 13;
    localparam int LVL_W     = 20;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MB_W      = 18;
    localparam int ACC_W     = 64;
    localparam int SLOPE_W   = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEND    = 3'd4;

    localparam logic signed [ACC_W-1:0] LVL_MAX64 = 64'sd524287;
    localparam logic signed [ACC_W-1:0] LVL_MIN64 = -64'sd524288;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE, OP_LEN, OP_NSTEP, OP_NDONE, OP_DEN1, OP_DEN2, OP_W1, OP_W2,
        OP_MX1, OP_MX2, OP_DX, OP_WIDX, OP_MY1, OP_MY2, OP_DY, OP_WLVL,
        OP_RD0, OP_RD1, OP_RD2, OP_SDIV, OP_SLOPE, OP_ADV, OP_MULS, OP_EMIT,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic unit_busy;
        logic n_more;
        logic pts_done;
        logic pcount_zero;
        logic empty;
        logic settle_adv;
        logic out_free;
    } status_t;

    function automatic logic signed [LVL_W-1:0] sat_lvl(input logic signed [ACC_W-1:0] v);
        logic signed [LVL_W-1:0] r;
        if (v > LVL_MAX64) begin
            r = LVL_MAX64[LVL_W-1:0];
        end else if (v < LVL_MIN64) begin
            r = LVL_MIN64[LVL_W-1:0];
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/bezier_segment_table_generator_unit.sv */
// Top level of the bezier segment table generator: controller plus datapath.
// Step word: accepted in the idle state; S_EMIT_CHK forms the product, then S_EMIT loads the output register
// once the output slot is free. Each point boundary crossed after a word adds a slope reload through the
// 64-step divider. Restart: points are counted, each curve point takes four multiplies and two divides,
// then the slope is loaded; no new word is taken until the sequencer is back in idle.
// Synchronous active-low reset loads register defaults and clears control, not point memory.
`timescale 1ns / 1ps

module bezier_segment_table_generator_unit #(
    parameter int TABLE_RES   = 1024,
    parameter int POINTS_STEP = 16,
    parameter int MAX_POINTS  = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bstg_pkg::LVL_W-1:0]  m_sample,
    output logic [bstg_pkg::IDX_W-1:0]         m_sample_index,
    output logic                               m_last,
    output logic                               m_empty_res,
    input  logic                               cfg_wr_en,
    input  logic [bstg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bstg_pkg::CFG_W-1:0]         cfg_wdata
);

    bstg_pkg::cmd_t    cmd;
    bstg_pkg::status_t st;

    // sequencer
    bstg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // arithmetic and storage
    bstg_dp #(
        .TABLE_RES   (TABLE_RES),
        .POINTS_STEP (POINTS_STEP),
        .MAX_POINTS  (MAX_POINTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_sample       (m_sample),
        .m_sample_index (m_sample_index),
        .m_last         (m_last),
        .m_empty_res    (m_empty_res)
    );

endmodule

/* sv/bstg_ctrl.sv */
// controller state machine sequencing point build, slope load and sample output
`timescale 1ns / 1ps

module bstg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_restart,
    output logic              s_ready,
    output bstg_pkg::cmd_t    cmd,
    input  bstg_pkg::status_t st
);

    typedef enum logic [4:0] {
        S_IDLE, S_LEN, S_NLOOP, S_DEN1, S_DEN2, S_PT, S_W2, S_MX1, S_MX2, S_DX,
        S_WIDX, S_MY1, S_MY2, S_DY, S_WLVL, S_WAIT, S_RD0, S_RD1, S_RD2, S_SDIV,
        S_SLOPE, S_SETTLE, S_EMIT_CHK, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   go_emit_reg, go_emit_next;

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        go_emit_next = go_emit_reg;
        cmd.op       = bstg_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    go_emit_next = 1'b1;
                    state_next   = s_restart ? S_LEN : S_EMIT_CHK;
                end
            end
            S_LEN: begin
                cmd.op     = bstg_pkg::OP_LEN;
                state_next = S_NLOOP;
            end
            S_NLOOP: begin
                if (st.n_more) begin
                    cmd.op = bstg_pkg::OP_NSTEP;
                end else begin
                    cmd.op     = bstg_pkg::OP_NDONE;
                    state_next = S_DEN1;
                end
            end
            S_DEN1: begin
                cmd.op     = bstg_pkg::OP_DEN1;
                state_next = S_DEN2;
            end
            S_DEN2: begin
                cmd.op     = bstg_pkg::OP_DEN2;
                state_next = S_PT;
            end
            S_PT: begin
                if (st.pts_done) begin
                    state_next = st.pcount_zero ? S_EMIT_CHK : S_RD0;
                end else begin
                    cmd.op     = bstg_pkg::OP_W1;
                    state_next = S_W2;
                end
            end
            S_W2: begin
                cmd.op     = bstg_pkg::OP_W2;
                state_next = S_MX1;
            end
            S_MX1: begin
                cmd.op     = bstg_pkg::OP_MX1;
                ret_next   = S_MX2;
                state_next = S_WAIT;
            end
            S_MX2: begin
                cmd.op     = bstg_pkg::OP_MX2;
                ret_next   = S_DX;
                state_next = S_WAIT;
            end
            S_DX: begin
                cmd.op     = bstg_pkg::OP_DX;
                ret_next   = S_WIDX;
                state_next = S_WAIT;
            end
            S_WIDX: begin
                cmd.op     = bstg_pkg::OP_WIDX;
                state_next = S_MY1;
            end
            S_MY1: begin
                cmd.op     = bstg_pkg::OP_MY1;
                ret_next   = S_MY2;
                state_next = S_WAIT;
            end
            S_MY2: begin
                cmd.op     = bstg_pkg::OP_MY2;
                ret_next   = S_DY;
                state_next = S_WAIT;
            end
            S_DY: begin
                cmd.op     = bstg_pkg::OP_DY;
                ret_next   = S_WLVL;
                state_next = S_WAIT;
            end
            S_WLVL: begin
                cmd.op     = bstg_pkg::OP_WLVL;
                state_next = S_PT;
            end
            S_WAIT: begin
                if (!st.unit_busy) begin
                    state_next = ret_reg;
                end
            end
            S_RD0: begin
                cmd.op     = bstg_pkg::OP_RD0;
                state_next = S_RD1;
            end
            S_RD1: begin
                cmd.op     = bstg_pkg::OP_RD1;
                state_next = S_RD2;
            end
            S_RD2: begin
                cmd.op     = bstg_pkg::OP_RD2;
                state_next = S_SDIV;
            end
            S_SDIV: begin
                cmd.op     = bstg_pkg::OP_SDIV;
                ret_next   = S_SLOPE;
                state_next = S_WAIT;
            end
            S_SLOPE: begin
                cmd.op     = bstg_pkg::OP_SLOPE;
                state_next = S_SETTLE;
            end
            S_SETTLE: begin
                if (st.settle_adv) begin
                    cmd.op     = bstg_pkg::OP_ADV;
                    state_next = S_RD0;
                end else begin
                    state_next = go_emit_reg ? S_EMIT_CHK : S_IDLE;
                end
            end
            S_EMIT_CHK: begin
                if (st.empty) begin
                    if (st.out_free) begin
                        cmd.op     = bstg_pkg::OP_EMPTY;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.op     = bstg_pkg::OP_MULS;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.op       = bstg_pkg::OP_EMIT;
                    go_emit_next = 1'b0;
                    state_next   = S_SETTLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            go_emit_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            go_emit_reg <= go_emit_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

/* sv/bstg_dp.sv */
// datapath: config registers, point memories, shared multiplier and divider, output word
`timescale 1ns / 1ps

module bstg_dp #(
    parameter int TABLE_RES   = 1024,
    parameter int POINTS_STEP = 16,
    parameter int MAX_POINTS  = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bstg_pkg::cmd_t                         cmd,
    output bstg_pkg::status_t                      st,
    input  logic                                   cfg_wr_en,
    input  logic [bstg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bstg_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic signed [bstg_pkg::LVL_W-1:0]      m_sample,
    output logic [bstg_pkg::IDX_W-1:0]             m_sample_index,
    output logic                                   m_last,
    output logic                                   m_empty_res
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW  = bstg_pkg::IDX_W;
    localparam int LW  = bstg_pkg::LVL_W;
    localparam int XW  = bstg_pkg::ACC_W;
    localparam int MB  = bstg_pkg::MB_W;
    localparam int MCW = $clog2(MB + 1);
    localparam int DCW = $clog2(XW + 1);
    localparam int WW  = 3 * CW + 2;
    localparam int CCW = 3 * CW + 14;

    // configuration registers
    logic [15:0]        start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic signed [15:0] bend_reg;

    // build state
    logic [IW-1:0]          len_reg, rem_reg;
    logic signed [16:0]     dy_reg;
    logic [CW-1:0]          n_reg, pcount_reg, i_reg, seg_reg;
    logic [2*CW-1:0]        sq_reg, wa_reg, ca_reg;
    logic [XW-1:0]          den_reg;
    logic [WW-1:0]          w_reg;
    logic [CCW-1:0]         c_reg;

    // shared multiplier
    logic signed [XW-1:0]   ma_reg, mp_reg;
    logic [MB-1:0]          mb_reg;
    logic                   mneg_reg;
    logic [MCW-1:0]         mcnt_reg;

    // shared divider
    logic [XW-1:0]          dq_reg, dr_reg, dd_reg;
    logic                   dneg_reg;
    logic [DCW-1:0]         dcnt_reg;

    // run state
    logic [IW-1:0]          step_reg, outpos_reg, cur_idx_reg, nxt_idx_reg;
    logic signed [LW-1:0]   cur_lvl_reg, nxt_lvl_reg;
    logic signed [bstg_pkg::SLOPE_W-1:0] slope_reg;
    logic signed [37:0]     prod_reg;

    // point memories
    logic [IW-1:0]          pidx_mem [MAX_POINTS];
    logic signed [LW-1:0]   plvl_mem [MAX_POINTS];
    logic [IW-1:0]          rd_idx_reg;
    logic signed [LW-1:0]   rd_lvl_reg;
    logic [AW-1:0]          rd_addr;

    // output word
    logic                   m_valid_reg, m_last_reg, m_empty_reg;
    logic signed [LW-1:0]   m_sample_reg;
    logic [IW-1:0]          m_index_reg;

    // combinational helpers
    logic signed [XW-1:0]   mul_res, q_floor, q_ceil;
    logic                   rnz, has_next, mul_start, div_start;
    logic signed [XW-1:0]   mul_a, div_num;
    logic signed [MB-1:0]   mul_b;
    logic [XW-1:0]          div_den;
    logic [16:0]            dx17;
    logic [31:0]            len_prod;
    logic signed [14:0]     sdx, sdxo, sdxa, idx_diff;
    logic signed [20:0]     sdy;
    logic [MB-1:0]          mul_bmag;
    logic [XW-1:0]          div_mag;
    logic [XW-1:0]          r_sh;
    logic signed [XW-1:0]   idx_val;
    logic [IW-1:0]          idx_clamp;
    logic [3*CW-1:0]        wprod;
    logic [CW:0]            seg_p1;

    assign mul_res = mneg_reg ? -mp_reg : mp_reg;
    assign rnz     = (dr_reg != '0);
    assign q_floor = dneg_reg ? (-$signed(dq_reg) - $signed(XW'(rnz))) : $signed(dq_reg);
    assign q_ceil  = dneg_reg ? -$signed(dq_reg) : ($signed(dq_reg) + $signed(XW'(rnz)));
    assign seg_p1  = {1'b0, seg_reg} + 1'b1;
    assign has_next = (seg_p1 < {1'b0, pcount_reg});
    assign idx_diff = $signed({2'b0, nxt_idx_reg}) - $signed({2'b0, cur_idx_reg});

    // segment length from the x span
    assign dx17     = {1'b0, end_x_reg} - {1'b0, start_x_reg};
    assign len_prod = 32'(dx17[16] ? 16'd0 : dx17[15:0]) * 32'(TABLE_RES) + 32'd32768;

    // slope operands
    always_comb begin
        if (has_next) begin
            sdx = idx_diff;
            sdy = $signed({nxt_lvl_reg[LW-1], nxt_lvl_reg}) - $signed({cur_lvl_reg[LW-1], cur_lvl_reg});
        end else begin
            sdx = (len_reg >= outpos_reg) ? $signed({2'b0, len_reg - outpos_reg}) : 15'sd0;
            sdy = $signed({5'b0, end_y_reg}) - $signed({cur_lvl_reg[LW-1], cur_lvl_reg});
        end
        sdxo = sdx | 15'sd1;
        sdxa = sdxo[14] ? -sdxo : sdxo;
    end

    assign wprod = (3*CW)'(wa_reg) * (3*CW)'(n_reg);

    // operand select for the shared multiplier and divider
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = $signed(XW'(w_reg));
        mul_b     = '0;
        div_num   = mul_res;
        div_den   = den_reg;
        case (cmd.op)
            bstg_pkg::OP_MX1: begin
                mul_start = 1'b1;
                mul_b     = 18'sd16384 - $signed({{2{bend_reg[15]}}, bend_reg});
            end
            bstg_pkg::OP_MX2: begin
                mul_start = 1'b1;
                mul_a     = mul_res + $signed(XW'(c_reg));
                mul_b     = $signed(MB'(len_reg));
            end
            bstg_pkg::OP_MY1: begin
                mul_start = 1'b1;
                mul_b     = $signed({{2{bend_reg[15]}}, bend_reg});
            end
            bstg_pkg::OP_MY2: begin
                mul_start = 1'b1;
                mul_a     = mul_res + $signed(XW'(c_reg));
                mul_b     = $signed({dy_reg[16], dy_reg});
            end
            bstg_pkg::OP_DX: begin
                div_start = 1'b1;
            end
            bstg_pkg::OP_DY: begin
                div_start = 1'b1;
                div_num   = (mul_res <<< 1) + $signed(den_reg);
                div_den   = den_reg << 1;
            end
            bstg_pkg::OP_SDIV: begin
                div_start = 1'b1;
                div_num   = ($signed(XW'(sdy)) <<< 1) + $signed(XW'(sdxa));
                div_den   = XW'(sdxa) << 1;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
        mul_bmag = mul_b[MB-1] ? MB'(-mul_b) : MB'(mul_b);
        div_mag  = div_num[XW-1] ? XW'(-div_num) : XW'(div_num);
    end

    // clamp of a ceiled point index to the segment
    always_comb begin
        idx_val = q_ceil;
        if (idx_val < 0) begin
            idx_clamp = '0;
        end else if (idx_val > $signed(XW'(len_reg))) begin
            idx_clamp = len_reg;
        end else begin
            idx_clamp = idx_val[IW-1:0];
        end
    end

    assign r_sh = {dr_reg[XW-2:0], dq_reg[XW-1]};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= 16'd0;
            start_y_reg <= 16'd0;
            end_x_reg   <= 16'hFFFF;
            end_y_reg   <= 16'hFFFF;
            bend_reg    <= 16'sd8192;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bstg_pkg::REG_START_X: start_x_reg <= cfg_wdata;
                bstg_pkg::REG_START_Y: start_y_reg <= cfg_wdata;
                bstg_pkg::REG_END_X:   end_x_reg   <= cfg_wdata;
                bstg_pkg::REG_END_Y:   end_y_reg   <= cfg_wdata;
                bstg_pkg::REG_BEND:    bend_reg    <= $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // shift-and-add multiplier, one multiplier bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg <= '0;
        end else if (mul_start) begin
            ma_reg   <= mul_a;
            mb_reg   <= mul_bmag;
            mneg_reg <= mul_b[MB-1];
            mp_reg   <= '0;
            mcnt_reg <= MCW'(MB);
        end else if (mcnt_reg != '0) begin
            if (mb_reg[0]) begin
                mp_reg <= mp_reg + ma_reg;
            end
            ma_reg   <= ma_reg <<< 1;
            mb_reg   <= mb_reg >> 1;
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (div_start) begin
            dq_reg   <= div_mag;
            dr_reg   <= '0;
            dd_reg   <= div_den;
            dneg_reg <= div_num[XW-1];
            dcnt_reg <= DCW'(XW);
        end else if (dcnt_reg != '0) begin
            if (r_sh >= dd_reg) begin
                dr_reg <= r_sh - dd_reg;
                dq_reg <= {dq_reg[XW-2:0], 1'b1};
            end else begin
                dr_reg <= r_sh;
                dq_reg <= {dq_reg[XW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // point memories, registered read
    assign rd_addr = (cmd.op == bstg_pkg::OP_RD1) ? seg_p1[AW-1:0] : seg_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.op == bstg_pkg::OP_WIDX) begin
            pidx_mem[i_reg[AW-1:0]] <= idx_clamp;
        end
        rd_idx_reg <= pidx_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == bstg_pkg::OP_WLVL) begin
            plvl_mem[i_reg[AW-1:0]] <= bstg_pkg::sat_lvl($signed(XW'(start_y_reg)) + q_floor);
        end
        rd_lvl_reg <= plvl_mem[rd_addr];
    end

    // payload registers of the build and run sequences
    always_ff @(posedge aclk) begin
        case (cmd.op)
            bstg_pkg::OP_LEN: begin
                dy_reg  <= $signed({1'b0, end_y_reg}) - $signed({1'b0, start_y_reg});
                rem_reg <= IW'(len_prod >> 16);
            end
            bstg_pkg::OP_NSTEP: rem_reg <= rem_reg - IW'(POINTS_STEP);
            bstg_pkg::OP_DEN1:  sq_reg  <= (2*CW)'(n_reg) * (2*CW)'(n_reg);
            bstg_pkg::OP_DEN2:  den_reg <= XW'((3*CW)'(sq_reg) * (3*CW)'(n_reg)) << 14;
            bstg_pkg::OP_W1: begin
                wa_reg <= (2*CW)'(i_reg) * (2*CW)'(n_reg - i_reg);
                ca_reg <= (2*CW)'(i_reg) * (2*CW)'(i_reg);
            end
            bstg_pkg::OP_W2: begin
                w_reg <= (WW'(wprod) << 1) + WW'(wprod);
                c_reg <= {(3*CW)'((3*CW)'(ca_reg) * (3*CW)'(i_reg)), 14'd0};
            end
            bstg_pkg::OP_RD1: begin
                cur_idx_reg <= rd_idx_reg;
                cur_lvl_reg <= rd_lvl_reg;
            end
            bstg_pkg::OP_RD2: begin
                nxt_idx_reg <= rd_idx_reg;
                nxt_lvl_reg <= rd_lvl_reg;
            end
            bstg_pkg::OP_MULS: prod_reg <= $signed({1'b0, step_reg}) * slope_reg;
            default: begin
            end
        endcase
    end

    // control state of the build and run sequences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            n_reg      <= '0;
            pcount_reg <= '0;
            i_reg      <= '0;
            seg_reg    <= '0;
            step_reg   <= '0;
            outpos_reg <= '0;
            slope_reg  <= '0;
        end else begin
            case (cmd.op)
                bstg_pkg::OP_LEN: begin
                    len_reg    <= IW'(len_prod >> 16);
                    n_reg      <= '0;
                    seg_reg    <= '0;
                    step_reg   <= '0;
                    outpos_reg <= '0;
                    slope_reg  <= '0;
                end
                bstg_pkg::OP_NSTEP: n_reg <= n_reg + 1'b1;
                bstg_pkg::OP_NDONE: begin
                    pcount_reg <= n_reg;
                    i_reg      <= '0;
                end
                bstg_pkg::OP_WLVL:  i_reg <= i_reg + 1'b1;
                bstg_pkg::OP_SLOPE: slope_reg <= q_floor[bstg_pkg::SLOPE_W-1:0];
                bstg_pkg::OP_ADV: begin
                    seg_reg  <= seg_reg + 1'b1;
                    step_reg <= '0;
                end
                bstg_pkg::OP_EMIT: begin
                    outpos_reg <= outpos_reg + 1'b1;
                    step_reg   <= step_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == bstg_pkg::OP_EMIT || cmd.op == bstg_pkg::OP_EMPTY) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == bstg_pkg::OP_EMIT) begin
            m_sample_reg <= bstg_pkg::sat_lvl($signed(XW'(cur_lvl_reg)) + $signed(XW'(prod_reg)));
            m_index_reg  <= outpos_reg;
            m_last_reg   <= ((outpos_reg + 1'b1) == len_reg);
            m_empty_reg  <= 1'b0;
        end else if (cmd.op == bstg_pkg::OP_EMPTY) begin
            m_sample_reg <= '0;
            m_index_reg  <= '0;
            m_last_reg   <= 1'b0;
            m_empty_reg  <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample       = m_sample_reg;
    assign m_sample_index = m_index_reg;
    assign m_last         = m_last_reg;
    assign m_empty_res    = m_empty_reg;

    // status to the controller
    assign st.unit_busy   = (mcnt_reg != '0) || (dcnt_reg != '0);
    assign st.n_more      = (rem_reg >= IW'(POINTS_STEP)) && (n_reg < CW'(MAX_POINTS));
    assign st.pts_done    = (i_reg == pcount_reg);
    assign st.pcount_zero = (pcount_reg == '0);
    assign st.empty       = (pcount_reg == '0) || (outpos_reg >= len_reg);
    assign st.settle_adv  = has_next && ($signed({2'b0, step_reg}) >= idx_diff);
    assign st.out_free    = !m_valid_reg || m_ready;

    // multiplier and divider never run together
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !((mcnt_reg != '0) && (dcnt_reg != '0)))
        else $error("multiplier and divider busy together");

    // a word is only loaded into a free output slot
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bstg_pkg::OP_EMIT || cmd.op == bstg_pkg::OP_EMPTY) |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten");

    // position never runs past the segment length
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg != '0) |-> (outpos_reg <= len_reg))
        else $error("output position beyond segment");

    // active segment is always a stored point
    a_seg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg != '0) |-> (seg_reg < pcount_reg))
        else $error("segment number beyond point count");

endmodule

/* tb/bezier_segment_table_generator_unit_test.sv */
// testbench for the bezier segment table generator: predicted table words checked field by field
`timescale 1ns / 1ps

module bezier_segment_table_generator_unit_test;

    localparam int TABLE_RES   = 1024;
    localparam int POINTS_STEP = 16;
    localparam int MAX_POINTS  = 64;
    localparam int ITEM_TARGET = 1950;

    typedef struct {
        logic signed [bstg_pkg::LVL_W-1:0] sample;
        logic [bstg_pkg::IDX_W-1:0]        sample_index;
        logic                              last;
        logic                              empty_res;
    } table_word_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_restart = 1'b0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [bstg_pkg::LVL_W-1:0]  m_sample;
    logic [bstg_pkg::IDX_W-1:0]         m_sample_index;
    logic                               m_last;
    logic                               m_empty_res;
    logic                               cfg_wr_en = 1'b0;
    logic [bstg_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [bstg_pkg::CFG_W-1:0]         cfg_wdata = '0;

    bezier_segment_table_generator_unit #(
        .TABLE_RES  (TABLE_RES),
        .POINTS_STEP(POINTS_STEP),
        .MAX_POINTS (MAX_POINTS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_sample_index(m_sample_index),
        .m_last        (m_last),
        .m_empty_res   (m_empty_res),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // overall limit on the run
    initial begin
        #80_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // curve model state
    longint cur_start_x = 0, cur_start_y = 0, cur_end_x = 65535, cur_end_y = 65535;
    longint cur_bend = 8192;
    longint pt_idx [MAX_POINTS];
    longint pt_lvl [MAX_POINTS];
    longint n_pts = 0, seg_len = 0, seg_no = 0, seg_step = 0, out_pos = 0, cur_slope = 0;

    table_word_t table_q[$];
    int err_count = 0;
    int words_sent = 0;
    int burst_left = 0;
    int big_segments = 0;

    function automatic longint div_dn(longint a, longint d);
        longint q;
        q = a / d;
        if (a % d < 0) q--;
        return q;
    endfunction

    function automatic longint div_up(longint a, longint d);
        longint q;
        q = a / d;
        if (a % d > 0) q++;
        return q;
    endfunction

    function automatic longint div_near(longint a, longint d);
        return div_dn(2 * a + d, 2 * d);
    endfunction

    function automatic longint clip_level(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // slope towards the next point, or the final ramp towards end_y
    function automatic void load_segment_slope();
        longint s, dxs, dys;
        s = (seg_no >= MAX_POINTS) ? MAX_POINTS - 1 : seg_no;
        if (s + 1 < n_pts) begin
            dxs = pt_idx[s+1] - pt_idx[s];
            dys = pt_lvl[s+1] - pt_lvl[s];
        end else begin
            dxs = seg_len - out_pos;
            if (dxs < 0) dxs = 0;
            dys = cur_end_y - pt_lvl[s];
        end
        dxs = dxs | 1;
        if (dxs < 0) dxs = -dxs;
        cur_slope = longint'(int'(div_near(dys, dxs)));
    endfunction

    // move past point boundaries already reached
    function automatic void skip_segments();
        while (seg_no + 1 < n_pts && seg_step >= pt_idx[seg_no+1] - pt_idx[seg_no]) begin
            seg_no++;
            seg_step = 0;
            load_segment_slope();
        end
    endfunction

    // sample the curve at the point grid
    function automatic void build_curve();
        longint dx, dy, n, len, den, wt, c, ax, ay, idx;
        dx = cur_end_x - cur_start_x;
        dy = cur_end_y - cur_start_y;
        if (dx < 0) dx = 0;
        len = (dx * TABLE_RES + 32768) / 65536;
        seg_len = len;
        n = len / POINTS_STEP;
        if (n > MAX_POINTS) n = MAX_POINTS;
        n_pts = n;
        if (n == 0) return;
        den = n * n * n * 16384;
        for (longint i = 0; i < n; i++) begin
            wt = 3 * i * (n - i) * n;
            c  = i * i * i * 16384;
            ax = wt * (16384 - cur_bend) + c;
            ay = wt * cur_bend + c;
            idx = div_up(len * ax, den);
            if (idx < 0) idx = 0;
            if (idx > len) idx = len;
            pt_idx[i] = idx;
            pt_lvl[i] = clip_level(cur_start_y + div_near(dy * ay, den));
        end
    endfunction

    function automatic table_word_t next_table_word(bit rs);
        table_word_t w;
        longint s, v;
        if (rs) begin
            build_curve();
            out_pos = 0;
            seg_no = 0;
            seg_step = 0;
            cur_slope = 0;
            if (n_pts != 0) begin
                load_segment_slope();
                skip_segments();
            end
        end
        if (n_pts == 0 || out_pos >= seg_len) begin
            w.sample = '0;
            w.sample_index = '0;
            w.last = 1'b0;
            w.empty_res = 1'b1;
            return w;
        end
        s = (seg_no >= MAX_POINTS) ? MAX_POINTS - 1 : seg_no;
        v = clip_level(pt_lvl[s] + seg_step * cur_slope);
        w.sample = v[bstg_pkg::LVL_W-1:0];
        w.sample_index = out_pos[bstg_pkg::IDX_W-1:0];
        w.last = (out_pos + 1 == seg_len);
        w.empty_res = 1'b0;
        out_pos++;
        seg_step++;
        skip_segments();
        return w;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s at word %0d: got %0d, want %0d", what, words_sent, got, want);
        err_count++;
    endtask

    // receiver stall pattern and result check
    int rx_mode = 0, rx_mode_left = 0, rx_hold = 0;
    logic rx_level = 1'b1;
    always @(posedge aclk) begin
        table_word_t w;
        if (m_valid && m_ready && aresetn) begin
            if (table_q.size() == 0) begin
                report("unexpected word", m_sample_index, -1);
            end else begin
                w = table_q.pop_front();
                if (m_sample !== w.sample) report("sample", m_sample, w.sample);
                if (m_sample_index !== w.sample_index)
                    report("sample_index", m_sample_index, w.sample_index);
                if (m_last !== w.last) report("last", m_last, w.last);
                if (m_empty_res !== w.empty_res) report("empty_res", m_empty_res, w.empty_res);
            end
        end
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_hold == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    rx_level = ~rx_level;
                end
                rx_hold--;
                m_ready <= rx_level;
            end
        endcase
    end

    // send one word in bursts with random gaps
    task automatic send_word(bit rs);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_restart <= rs;
        do @(posedge aclk); while (!s_ready);
        table_q.push_back(next_table_word(rs));
        words_sent++;
        burst_left--;
    endtask

    task automatic send_steps(int count);
        repeat (count) send_word(1'b0);
    endtask

    // wait until every word is back and the sequencer is back in idle
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (table_q.size() == 0);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [bstg_pkg::CFG_IDX_W-1:0] idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[bstg_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bstg_pkg::REG_START_X: cur_start_x = value & 16'hFFFF;
            bstg_pkg::REG_START_Y: cur_start_y = value & 16'hFFFF;
            bstg_pkg::REG_END_X:   cur_end_x = value & 16'hFFFF;
            bstg_pkg::REG_END_Y:   cur_end_y = value & 16'hFFFF;
            bstg_pkg::REG_BEND:    cur_bend = longint'(signed'(value[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_segment(longint sx, longint sy, longint ex, longint ey, longint bd);
        wait_idle();
        write_reg(bstg_pkg::REG_START_X, sx);
        write_reg(bstg_pkg::REG_START_Y, sy);
        write_reg(bstg_pkg::REG_END_X, ex);
        write_reg(bstg_pkg::REG_END_Y, ey);
        write_reg(bstg_pkg::REG_BEND, bd);
    endtask

    // empty before any restart, then the full-width default segment
    task automatic test_defaults();
        send_steps(2);
        send_word(1'b1);
        send_steps(2);
    endtask

    task automatic test_end_before_start();
        set_segment(40000, 1000, 1000, 60000, 8192);
        send_word(1'b1);
        send_word(1'b0);
    endtask

    // extreme levels and bends, and a segment too short for any point
    task automatic test_extremes();
        set_segment(0, 65535, 2048, 0, -32768);
        send_word(1'b1);
        send_steps(2);
        set_segment(65535 - 2048, 0, 65535, 65535, 32767);
        send_word(1'b1);
        send_steps(2);
        set_segment(100, 500, 740, 900, 0);
        send_word(1'b1);
        send_word(1'b0);
    endtask

    // end_y rewritten partway through a segment
    task automatic test_end_y_rewrite();
        set_segment(0, 30000, 1280, 40000, 16384);
        send_word(1'b1);
        send_steps(3);
        wait_idle();
        write_reg(bstg_pkg::REG_END_Y, 0);
        send_steps(2);
    endtask

    // random segments, mostly run to their end, with noise restarts
    task automatic test_random_segments();
        longint sx, ex, k;
        int pick;
        while (words_sent < ITEM_TARGET) begin
            wait_idle();
            sx = $urandom_range(0, 65535);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                ex = $urandom_range(0, 65535);
            end else if (pick < 10 && big_segments < 3) begin
                big_segments++;
                sx = $urandom_range(0, 2000);
                ex = 65535;
            end else begin
                ex = sx + $urandom_range(0, 160 * 64);
                if (ex > 65535) ex = 65535;
            end
            if ($urandom_range(0, 9) != 0) write_reg(bstg_pkg::REG_START_X, sx);
            if ($urandom_range(0, 9) != 0) write_reg(bstg_pkg::REG_END_X, ex);
            write_reg(bstg_pkg::REG_START_Y,
                      ($urandom_range(0, 7) == 0) ? 65535 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 65535));
            write_reg(bstg_pkg::REG_END_Y,
                      ($urandom_range(0, 7) == 0) ? 65535 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 65535));
            case ($urandom_range(0, 5))
                0: write_reg(bstg_pkg::REG_BEND, 16'h8000);
                1: write_reg(bstg_pkg::REG_BEND, 16'h7FFF);
                default: write_reg(bstg_pkg::REG_BEND, $urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 9) != 0) send_word(1'b1);
            k = seg_len + $urandom_range(0, 3);
            if ($urandom_range(0, 6) == 0) k = $urandom_range(1, 20);
            // keep the total close to the item target
            if (k > ITEM_TARGET - words_sent) k = ITEM_TARGET - words_sent;
            if (k < 0) k = 0;
            if ($urandom_range(0, 9) == 0) begin
                send_steps(int'(k / 2));
                wait_idle();
                write_reg(bstg_pkg::REG_END_Y, $urandom_range(0, 65535));
                k = k - k / 2;
            end
            for (longint j = 0; j < k; j++)
                send_word($urandom_range(0, 39) == 0);
        end
    endtask

    // test sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_end_before_start();
        test_extremes();
        test_end_y_rewrite();
        test_random_segments();
        s_valid <= 1'b0;
        wait (table_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
